>>> hdl/mmh64a_pkg.sv
// ----------------------------------------------------------------------------
// mmh64a_pkg
// Constants, operation codes and control/status types shared by the
// hash unit's controller and datapath.
// ----------------------------------------------------------------------------
package mmh64a_pkg;

    localparam logic [63:0] HASH_SEED  = 64'h5053_E8BB_AB66_9952;
    localparam logic [63:0] HASH_MUL   = 64'hC6A4_A793_5BD1_E995;
    localparam int          HASH_SHIFT = 47;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [3:0]  WORD_BYTES = 4'd8;

    typedef enum logic [2:0] {
        OP_SEED,
        OP_WORD,
        OP_KMIX,
        OP_HFULL,
        OP_HTAIL,
        OP_HAVAL
    } mmh_op_t;

    typedef struct packed {
        logic    load;
        logic    mul_start;
        mmh_op_t op;
    } mmh_cmd_t;

    typedef struct packed {
        logic first;
        logic last;
        logic full;
        logic empty;
        logic mul_done;
        logic out_free;
    } mmh_status_t;

endpackage

>>> hdl/mmh64a_mul.sv
// ----------------------------------------------------------------------------
// mmh64a_mul
// Multiplies a 64-bit operand by the hash constant modulo 2^64, using one
// 32x32 multiplier for the low-low, low-high and high-low partial products.
// ----------------------------------------------------------------------------
module mmh64a_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        busy,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [31:0] MUL_LO = mmh64a_pkg::HASH_MUL[31:0];
    localparam logic [31:0] MUL_HI = mmh64a_pkg::HASH_MUL[63:32];

    logic [63:0] a_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] acc_lo_reg;
    logic [31:0] acc_hi_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    always_comb begin
        mul_a = (step_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
        mul_b = (step_reg == 2'd1) ? MUL_HI : MUL_LO;
        prod  = 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end else if (busy_reg) begin
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= 2'd0;
                end else begin
                    step_reg <= step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            a_reg <= operand;
        end
        if (busy_reg) begin
            if (step_reg == 2'd0) begin
                acc_lo_reg <= prod[31:0];
                acc_hi_reg <= prod[63:32];
            end else begin
                acc_hi_reg <= acc_hi_reg + prod[31:0];
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = {acc_hi_reg, acc_lo_reg};

endmodule

>>> hdl/mmh64a_datapath.sv
// ----------------------------------------------------------------------------
// mmh64a_datapath
// Item registers, running hash, byte counters, operand selection for the
// shared multiplier and the result register.
// ----------------------------------------------------------------------------
module mmh64a_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mmh64a_pkg::mmh_cmd_t      cmd,
    output mmh64a_pkg::mmh_status_t   status,
    input  logic [63:0]               s_word,
    input  logic [3:0]                s_byte_count,
    input  logic                      s_first,
    input  logic                      s_last,
    input  logic [15:0]               s_total_length,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [63:0]               m_hash_value,
    output logic                      m_length_mismatch
);

    logic [63:0] word_reg;
    logic [3:0]  n_reg;
    logic        first_reg;
    logic        last_reg;
    logic [15:0] tlen_reg;
    logic [63:0] hash_reg;
    logic [63:0] k_reg;
    logic [15:0] bytes_seen_reg;
    logic [15:0] declared_reg;
    logic        m_valid_reg;
    logic [63:0] m_hash_value_reg;
    logic        m_length_mismatch_reg;

    logic [3:0]  n_eff;
    logic [63:0] byte_mask;
    logic [15:0] count_base;
    logic [16:0] count_sum;
    logic [15:0] count_next;
    logic [63:0] mul_operand;
    logic        mul_busy;
    logic        mul_done;
    logic [63:0] mul_result;

    always_comb begin
        n_eff = (s_byte_count > mmh64a_pkg::WORD_BYTES) ? mmh64a_pkg::WORD_BYTES
                                                        : s_byte_count;
        for (int i = 0; i < 8; i++) begin
            byte_mask[8*i +: 8] = (4'(i) < n_eff) ? 8'hFF : 8'h00;
        end
        count_base = s_first ? 16'd0 : bytes_seen_reg;
        count_sum  = 17'(count_base) + 17'(n_eff);
        count_next = count_sum[16] ? mmh64a_pkg::COUNT_MAX : count_sum[15:0];
    end

    always_comb begin
        case (cmd.op)
            mmh64a_pkg::OP_SEED:  mul_operand = {48'd0, tlen_reg};
            mmh64a_pkg::OP_WORD:  mul_operand = word_reg;
            mmh64a_pkg::OP_KMIX:  mul_operand = k_reg ^ (k_reg >> mmh64a_pkg::HASH_SHIFT);
            mmh64a_pkg::OP_HFULL: mul_operand = hash_reg ^ k_reg;
            mmh64a_pkg::OP_HTAIL: mul_operand = hash_reg ^ word_reg;
            mmh64a_pkg::OP_HAVAL:
                mul_operand = hash_reg ^ (hash_reg >> mmh64a_pkg::HASH_SHIFT);
            default:              mul_operand = 64'd0;
        endcase
    end

    mmh64a_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .operand (mul_operand),
        .busy    (mul_busy),
        .done    (mul_done),
        .result  (mul_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg       <= 64'd0;
            bytes_seen_reg <= 16'd0;
            declared_reg   <= 16'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                bytes_seen_reg <= count_next;
                if (s_first) begin
                    declared_reg <= s_total_length;
                end
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (mul_done) begin
                case (cmd.op)
                    mmh64a_pkg::OP_SEED:  hash_reg <= mmh64a_pkg::HASH_SEED ^ mul_result;
                    mmh64a_pkg::OP_HFULL: hash_reg <= mul_result;
                    mmh64a_pkg::OP_HTAIL: hash_reg <= mul_result;
                    mmh64a_pkg::OP_HAVAL: m_valid_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg  <= s_word & byte_mask;
            n_reg     <= n_eff;
            first_reg <= s_first;
            last_reg  <= s_last;
            tlen_reg  <= s_total_length;
        end
        if (mul_done) begin
            case (cmd.op)
                mmh64a_pkg::OP_WORD: k_reg <= mul_result;
                mmh64a_pkg::OP_KMIX: k_reg <= mul_result;
                mmh64a_pkg::OP_HAVAL: begin
                    m_hash_value_reg      <= mul_result
                                             ^ (mul_result >> mmh64a_pkg::HASH_SHIFT);
                    m_length_mismatch_reg <= (bytes_seen_reg != declared_reg);
                end
                default: ;
            endcase
        end
    end

    assign status.first    = first_reg;
    assign status.last     = last_reg;
    assign status.full     = (n_reg == mmh64a_pkg::WORD_BYTES);
    assign status.empty    = (n_reg == 4'd0);
    assign status.mul_done = mul_done;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_hash_value      = m_hash_value_reg;
    assign m_length_mismatch = m_length_mismatch_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> !mul_busy)
        else $error("Multiplier started while busy.");

    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !mul_busy && !cmd.mul_start)
        else $error("Item loaded while a multiplication is in flight.");

    a_result_posted: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done && cmd.op == mmh64a_pkg::OP_HAVAL |=> m_valid_reg)
        else $error("Finished hash was not posted to the result register.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done && cmd.op == mmh64a_pkg::OP_HAVAL |-> !m_valid_reg)
        else $error("Result register overwritten before its transfer.");

endmodule

>>> hdl/mmh64a_ctrl.sv
// ----------------------------------------------------------------------------
// mmh64a_ctrl
// Sequencer that steps each accepted item through what it needs of seeding,
// word mixing, tail folding and the final avalanche on the shared multiplier.
// ----------------------------------------------------------------------------
module mmh64a_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    output mmh64a_pkg::mmh_cmd_t      cmd,
    input  mmh64a_pkg::mmh_status_t   status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEED,
        S_WORD,
        S_KMIX,
        S_HFULL,
        S_HTAIL,
        S_AVAL_WAIT,
        S_AVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t body_state;
    state_t end_state;
    logic   start_reg;
    logic   start_next;

    always_comb begin
        end_state  = status.last ? S_AVAL_WAIT : S_IDLE;
        body_state = status.full ? S_WORD : (!status.empty ? S_HTAIL : end_state);
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_DISPATCH;
            S_DISPATCH:  state_next = status.first ? S_SEED : body_state;
            S_SEED:      if (status.mul_done) state_next = body_state;
            S_WORD:      if (status.mul_done) state_next = S_KMIX;
            S_KMIX:      if (status.mul_done) state_next = S_HFULL;
            S_HFULL:     if (status.mul_done) state_next = end_state;
            S_HTAIL:     if (status.mul_done) state_next = end_state;
            S_AVAL_WAIT: if (status.out_free) state_next = S_AVAL;
            S_AVAL:      if (status.mul_done) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
        start_next = (state_next != state_reg)
                     && (state_next inside {S_SEED, S_WORD, S_KMIX, S_HFULL,
                                            S_HTAIL, S_AVAL});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd.load      = s_valid && s_ready;
        cmd.mul_start = start_reg;
        case (state_reg)
            S_SEED:  cmd.op = mmh64a_pkg::OP_SEED;
            S_WORD:  cmd.op = mmh64a_pkg::OP_WORD;
            S_KMIX:  cmd.op = mmh64a_pkg::OP_KMIX;
            S_HFULL: cmd.op = mmh64a_pkg::OP_HFULL;
            S_HTAIL: cmd.op = mmh64a_pkg::OP_HTAIL;
            S_AVAL:  cmd.op = mmh64a_pkg::OP_HAVAL;
            default: cmd.op = mmh64a_pkg::OP_SEED;
        endcase
    end

    a_done_in_op: assert property (@(posedge aclk) disable iff (!aresetn)
        status.mul_done |-> state_reg == S_SEED || state_reg == S_WORD
                         || state_reg == S_KMIX || state_reg == S_HFULL
                         || state_reg == S_HTAIL || state_reg == S_AVAL)
        else $error("Multiplier finished outside an operation state.");

    a_dispatch_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == S_DISPATCH)
        else $error("Accepted item was not dispatched.");

    a_single_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |=> !cmd.mul_start)
        else $error("Multiplier start held for more than one cycle.");

endmodule

>>> hdl/murmurhash64a_stream_unit.sv
// Items of 1 to 7 bytes fold in a tail, items of 8 bytes mix a full word and
// empty items add nothing; a first item also seeds the hash and a last item
// runs the avalanche once the result register is free. One item at a time is
// taken; each needs up to five 64-bit products on the single 32x32 multiplier.
// Reset (aresetn low, synchronous) clears the running hash and byte counts to
// zero and empties the result register.
// ----------------------------------------------------------------------------
// murmurhash64a_stream_unit
// Streaming MurmurHash64A with a fixed seed over little-endian 64-bit words,
// with a declared-length check on the final transfer.
// ----------------------------------------------------------------------------
module murmurhash64a_stream_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_word,
    input  logic [3:0]  s_byte_count,
    input  logic        s_first,
    input  logic        s_last,
    input  logic [15:0] s_total_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash_value,
    output logic        m_length_mismatch
);

    mmh64a_pkg::mmh_cmd_t    cmd;
    mmh64a_pkg::mmh_status_t status;

    mmh64a_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    mmh64a_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_word            (s_word),
        .s_byte_count      (s_byte_count),
        .s_first           (s_first),
        .s_last            (s_last),
        .s_total_length    (s_total_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hash_value      (m_hash_value),
        .m_length_mismatch (m_length_mismatch)
    );

endmodule
